/* hw/rtl/tpd_pkg.sv */
// shared constants, codes and types for the two-phase task dispatcher
`timescale 1ns / 1ps

package tpd_pkg;

   // table sizes and derived widths
   localparam int MAP_N    = 32;
   localparam int RED_N    = 16;
   localparam int CELL_N   = MAP_N + RED_N;
   localparam int POS_W    = $clog2(CELL_N);
   localparam int CNT_W    = $clog2(CELL_N + 1);

   // field widths
   localparam int FUNC_W    = 2;
   localparam int KIND_W    = 2;
   localparam int TASK_W    = 5;
   localparam int WORKER_W  = 8;
   localparam int REPLY_W   = 2;
   localparam int MCOUNT_W  = 6;
   localparam int RCOUNT_W  = 5;
   localparam int TIMEOUT_W = 16;
   localparam int NOW_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // configuration reset values
   localparam logic [MCOUNT_W-1:0]  MAP_COUNT_RST = MCOUNT_W'(1);
   localparam logic [RCOUNT_W-1:0]  RED_COUNT_RST = RCOUNT_W'(2);
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = TIMEOUT_W'(30);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAP_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RED_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT   = 2'd2;

   // request function codes
   localparam logic [FUNC_W-1:0] FN_REQUEST = 2'd0;
   localparam logic [FUNC_W-1:0] FN_DONE    = 2'd1;
   localparam logic [FUNC_W-1:0] FN_TICK    = 2'd2;

   // done report kinds
   localparam logic [KIND_W-1:0] KIND_MAP    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REDUCE = 2'd1;

   // reply codes
   localparam logic [REPLY_W-1:0] RPLY_MAP     = 2'd0;
   localparam logic [REPLY_W-1:0] RPLY_REDUCE  = 2'd1;
   localparam logic [REPLY_W-1:0] RPLY_WAIT    = 2'd2;
   localparam logic [REPLY_W-1:0] RPLY_ALLDONE = 2'd3;

   // task status codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // table write operations
   localparam logic [1:0] WR_NONE  = 2'd0;
   localparam logic [1:0] WR_DONE  = 2'd1;
   localparam logic [1:0] WR_CLAIM = 2'd2;

   // write command broadcast to the cells
   typedef struct packed {
      logic [1:0]          op;
      logic [POS_W-1:0]    pos;
      logic [WORKER_W-1:0] worker;
   } wr_type;

   // scan record that travels from cell to cell
   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] pos;
      logic             map_found;
      logic [POS_W-1:0] map_idx;
      logic             map_again;
      logic             map_done;
      logic             red_found;
      logic [POS_W-1:0] red_idx;
      logic             red_again;
      logic             red_done;
   } scan_type;

endpackage

/* hw/rtl/two_phase_task_dispatcher.sv */
// top level of the two-phase task dispatcher
`timescale 1ns / 1ps

// Hands out map tasks, then reduce tasks, to workers that ask for work.
// Request channel (req_valid / req_stall): func selects a worker request,
// a done report or a one-second tick. Requests and done reports get one
// response each on the rsp channel; ticks and unused codes get none.
// Response channel (rsp_valid / rsp_stall): reply code, task index and a
// reissue flag for a task taken back after its timeout.
// Configuration (csr_wr_en / csr_index / csr_wdata) sets the map count,
// reduce count and timeout; write it only while the block is idle.
// Sequence: a tick only advances the seconds counter. A request or done
// report is handled in order: the done report is applied, the scan record
// is launched at the head of the chain and walks it one cell per cycle,
// the chosen task is claimed as the record leaves the last cell, and the
// answer is loaded into the response register. One request is worked on
// at a time; the next is taken once the block is back in idle. Once the
// job is finished, the scan is skipped and the response register is loaded.
// Reset clears all task status to idle, the seconds counter and the
// finished flag, and loads the register defaults (1 map, 2 reduces, 30 s).
// A stalled response holds its register; the next request can be accepted
// meanwhile and its response waits until the register is free.
module two_phase_task_dispatcher (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tpd_pkg::FUNC_W-1:0]    req_func,
   input  logic [tpd_pkg::KIND_W-1:0]    req_done_kind,
   input  logic [tpd_pkg::TASK_W-1:0]    req_done_task,
   input  logic [tpd_pkg::WORKER_W-1:0]  req_worker_id,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tpd_pkg::REPLY_W-1:0]   rsp_reply,
   output logic [tpd_pkg::TASK_W-1:0]    rsp_task_index,
   output logic                          rsp_reissued,
   input  logic                          csr_wr_en,
   input  logic [tpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tpd_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import tpd_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_APPLY  = 3'd1;
   localparam logic [2:0] S_LAUNCH = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_REPLY  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [MCOUNT_W-1:0]  map_count_ff, map_count_in;
   logic [RCOUNT_W-1:0]  red_count_ff, red_count_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [NOW_W-1:0]     now_ff, now_in;
   logic                 finished_ff, finished_in;

   logic [FUNC_W-1:0]    func_ff, func_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [TASK_W-1:0]    task_ff, task_in;
   logic [WORKER_W-1:0]  worker_ff, worker_in;

   logic [REPLY_W-1:0]   res_reply_ff, res_reply_in;
   logic [TASK_W-1:0]    res_idx_ff, res_idx_in;
   logic                 res_again_ff, res_again_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [REPLY_W-1:0]   rsp_reply_ff, rsp_reply_in;
   logic [TASK_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic                 rsp_again_ff, rsp_again_in;

   logic [CNT_W-1:0]     map_used;
   logic [CNT_W-1:0]     red_used;
   logic                 req_take;
   wr_type               wr;
   scan_type             rec_head;
   scan_type             rec_tail;

   // counts in use, capped at the table sizes
   assign map_used = (32'(map_count_ff) > 32'(MAP_N)) ? CNT_W'(MAP_N) : CNT_W'(map_count_ff);
   assign red_used = (32'(red_count_ff) > 32'(RED_N)) ? CNT_W'(RED_N) : CNT_W'(red_count_ff);

   assign req_stall = state_ff != S_IDLE;
   assign req_take  = req_valid && !req_stall;

   // configuration writes
   always_comb begin
      map_count_in = map_count_ff;
      red_count_in = red_count_ff;
      timeout_in   = timeout_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_MAP_COUNT: map_count_in = csr_wdata[MCOUNT_W-1:0];
            REG_RED_COUNT: red_count_in = csr_wdata[RCOUNT_W-1:0];
            REG_TIMEOUT:   timeout_in   = csr_wdata[TIMEOUT_W-1:0];
            default:       map_count_in = map_count_ff;
         endcase
      end
   end

   // scan record injected at the head of the chain
   always_comb begin
      rec_head           = '0;
      rec_head.valid     = state_ff == S_LAUNCH;
      rec_head.map_done  = 1'b1;
      rec_head.red_done  = 1'b1;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      finished_in  = finished_ff;
      func_in      = func_ff;
      kind_in      = kind_ff;
      task_in      = task_ff;
      worker_in    = worker_ff;
      res_reply_in = res_reply_ff;
      res_idx_in   = res_idx_ff;
      res_again_in = res_again_ff;
      wr           = '0;
      wr.op        = WR_NONE;
      wr.worker    = worker_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               func_in   = req_func;
               kind_in   = req_done_kind;
               task_in   = req_done_task;
               worker_in = req_worker_id;
               if (req_func == FN_TICK) begin
                  now_in = now_ff + NOW_W'(1);
               end else if (req_func == FN_REQUEST || req_func == FN_DONE) begin
                  if (finished_ff) begin
                     res_reply_in = RPLY_ALLDONE;
                     res_idx_in   = '0;
                     res_again_in = 1'b0;
                     state_in     = S_REPLY;
                  end else begin
                     state_in = S_APPLY;
                  end
               end
            end
         end
         S_APPLY: begin
            // apply a done report to the named in-progress task
            if (func_ff == FN_DONE) begin
               if (kind_ff == KIND_MAP && CNT_W'(task_ff) < map_used) begin
                  wr.op  = WR_DONE;
                  wr.pos = POS_W'(task_ff);
               end else if (kind_ff == KIND_REDUCE && CNT_W'(task_ff) < red_used) begin
                  wr.op  = WR_DONE;
                  wr.pos = POS_W'(MAP_N) + POS_W'(task_ff);
               end
            end
            state_in = S_LAUNCH;
         end
         S_LAUNCH: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // record leaves the last cell: pick the answer and claim
            if (rec_tail.valid) begin
               res_idx_in   = '0;
               res_again_in = 1'b0;
               if (rec_tail.map_done && rec_tail.red_done) begin
                  finished_in  = 1'b1;
                  res_reply_in = RPLY_ALLDONE;
               end else if (rec_tail.map_found) begin
                  wr.op        = WR_CLAIM;
                  wr.pos       = rec_tail.map_idx;
                  res_reply_in = RPLY_MAP;
                  res_idx_in   = TASK_W'(rec_tail.map_idx);
                  res_again_in = rec_tail.map_again;
               end else if (rec_tail.map_done && rec_tail.red_found) begin
                  wr.op        = WR_CLAIM;
                  wr.pos       = POS_W'(MAP_N) + rec_tail.red_idx;
                  res_reply_in = RPLY_REDUCE;
                  res_idx_in   = TASK_W'(rec_tail.red_idx);
                  res_again_in = rec_tail.red_again;
               end else begin
                  res_reply_in = RPLY_WAIT;
               end
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_reply_in = rsp_reply_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_again_in = rsp_again_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_REPLY && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in = 1'b1;
         rsp_reply_in = res_reply_ff;
         rsp_idx_in   = res_idx_ff;
         rsp_again_in = res_again_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         map_count_ff <= MAP_COUNT_RST;
         red_count_ff <= RED_COUNT_RST;
         timeout_ff   <= TIMEOUT_RST;
         now_ff       <= '0;
         finished_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_count_ff <= map_count_in;
         red_count_ff <= red_count_in;
         timeout_ff   <= timeout_in;
         now_ff       <= now_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      kind_ff      <= kind_in;
      task_ff      <= task_in;
      worker_ff    <= worker_in;
      res_reply_ff <= res_reply_in;
      res_idx_ff   <= res_idx_in;
      res_again_ff <= res_again_in;
      rsp_reply_ff <= rsp_reply_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_again_ff <= rsp_again_in;
   end

   // task tables
   tpd_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .now      (now_ff),
      .timeout  (timeout_ff),
      .map_used (map_used),
      .red_used (red_used),
      .rec_head (rec_head),
      .rec_tail (rec_tail)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reply      = rsp_reply_ff;
   assign rsp_task_index = rsp_idx_ff;
   assign rsp_reissued   = rsp_again_ff;

endmodule

/* hw/rtl/tpd_cell.sv */
// one task entry: status, stamp and owner, plus one step of the table scan
`timescale 1ns / 1ps

module tpd_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         sel,
   input  tpd_pkg::wr_type              wr,
   input  logic [tpd_pkg::NOW_W-1:0]    now,
   input  logic [tpd_pkg::TIMEOUT_W-1:0] timeout,
   input  logic [tpd_pkg::CNT_W-1:0]    map_used,
   input  logic [tpd_pkg::CNT_W-1:0]    red_used,
   input  tpd_pkg::scan_type            rec_in,
   output tpd_pkg::scan_type            rec_out
);
   import tpd_pkg::*;

   logic [1:0]          status_ff, status_in;
   logic [NOW_W-1:0]    stamp_ff;
   logic [WORKER_W-1:0] owner_ff;
   scan_type            rec_ff, rec_in_next;

   logic                is_red;
   logic [POS_W-1:0]    local_idx;
   logic [CNT_W-1:0]    used;
   logic                active;
   logic [NOW_W-1:0]    elapsed;
   logic                fresh;
   logic                stale;
   logic                hit;

   // status update from done reports and claims
   always_comb begin
      status_in = status_ff;
      if (sel && wr.op == WR_DONE && status_ff == ST_BUSY) begin
         status_in = ST_DONE;
      end else if (sel && wr.op == WR_CLAIM) begin
         status_in = ST_BUSY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_IDLE;
      end else begin
         status_ff <= status_in;
      end
   end

   // stamp and owner are written on a claim only
   always_ff @(posedge clock) begin
      if (sel && wr.op == WR_CLAIM) begin
         stamp_ff <= now;
         owner_ff <= wr.worker;
      end
   end

   // which table this position belongs to and whether it is in use
   always_comb begin
      is_red    = rec_in.pos >= POS_W'(MAP_N);
      local_idx = is_red ? rec_in.pos - POS_W'(MAP_N) : rec_in.pos;
      used      = is_red ? red_used : map_used;
      active    = CNT_W'(local_idx) < used;
      elapsed   = now - stamp_ff;
      fresh     = status_ff == ST_IDLE;
      stale     = status_ff == ST_BUSY && elapsed > NOW_W'(timeout);
      hit       = active && (fresh || stale);
   end

   // fold this entry into the record
   always_comb begin
      rec_in_next     = rec_in;
      rec_in_next.pos = rec_in.pos + POS_W'(1);
      if (rec_in.valid && active) begin
         if (is_red) begin
            if (status_ff != ST_DONE) begin
               rec_in_next.red_done = 1'b0;
            end
            if (hit && !rec_in.red_found) begin
               rec_in_next.red_found = 1'b1;
               rec_in_next.red_idx   = local_idx;
               rec_in_next.red_again = stale;
            end
         end else begin
            if (status_ff != ST_DONE) begin
               rec_in_next.map_done = 1'b0;
            end
            if (hit && !rec_in.map_found) begin
               rec_in_next.map_found = 1'b1;
               rec_in_next.map_idx   = local_idx;
               rec_in_next.map_again = stale;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
      end else begin
         rec_ff <= rec_in_next;
      end
   end

   assign rec_out = rec_ff;

endmodule

/* hw/rtl/tpd_chain.sv */
// row of task cells: map entries first, then reduce entries
`timescale 1ns / 1ps

module tpd_chain (
   input  logic                          clock,
   input  logic                          reset,
   input  tpd_pkg::wr_type               wr,
   input  logic [tpd_pkg::NOW_W-1:0]     now,
   input  logic [tpd_pkg::TIMEOUT_W-1:0] timeout,
   input  logic [tpd_pkg::CNT_W-1:0]     map_used,
   input  logic [tpd_pkg::CNT_W-1:0]     red_used,
   input  tpd_pkg::scan_type             rec_head,
   output tpd_pkg::scan_type             rec_tail
);
   import tpd_pkg::*;

   scan_type         link [CELL_N+1];
   logic [CELL_N-1:0] sel;

   assign link[0]  = rec_head;
   assign rec_tail = link[CELL_N];

   // one cell per table entry, record handed on every cycle
   for (genvar i = 0; i < CELL_N; i++) begin : g_cell
      assign sel[i] = wr.pos == POS_W'(i);

      tpd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .sel      (sel[i]),
         .wr       (wr),
         .now      (now),
         .timeout  (timeout),
         .map_used (map_used),
         .red_used (red_used),
         .rec_in   (link[i]),
         .rec_out  (link[i+1])
      );
   end

endmodule

/* sim/tb_two_phase_task_dispatcher.sv */
// self-checking testbench for the two-phase task dispatcher
`timescale 1ns / 1ps

module tb_two_phase_task_dispatcher;
   import tpd_pkg::*;

   // codes the package leaves unnamed
   localparam logic [FUNC_W-1:0]    FN_UNUSED  = 2'd3;
   localparam logic [KIND_W-1:0]    KIND_OTHER = 2'd2;
   localparam logic [KIND_W-1:0]    KIND_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE  = 2'd3;

   localparam int RANDOM_ITEMS  = 1500;
   localparam int SETTLE_CYCLES = CELL_N + 12;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int RUN_LIMIT_NS  = 25_000_000;

   // shadow of the task tables; predicts one answer per request or done report
   class dispatcher_shadow;
      typedef struct {
         logic [REPLY_W-1:0] reply;
         logic [TASK_W-1:0]  index;
         logic               reissued;
      } answer_type;

      logic [1:0]           map_state [MAP_N];
      logic [NOW_W-1:0]     map_stamp [MAP_N];
      logic [WORKER_W-1:0]  map_owner [MAP_N];
      logic [1:0]           red_state [RED_N];
      logic [NOW_W-1:0]     red_stamp [RED_N];
      logic [WORKER_W-1:0]  red_owner [RED_N];
      logic [NOW_W-1:0]     seconds;
      bit                   finished;
      logic [MCOUNT_W-1:0]  map_count;
      logic [RCOUNT_W-1:0]  red_count;
      logic [TIMEOUT_W-1:0] timeout;
      answer_type           answers_due[$];
      int                   errors;
      int                   ticks;
      int                   ignored;
      int                   reissues;
      int                   tally [4];

      function new();
         foreach (map_state[i]) begin
            map_state[i] = ST_IDLE;
            map_stamp[i] = '0;
            map_owner[i] = '0;
         end
         foreach (red_state[i]) begin
            red_state[i] = ST_IDLE;
            red_stamp[i] = '0;
            red_owner[i] = '0;
         end
         seconds   = '0;
         finished  = 1'b0;
         map_count = MAP_COUNT_RST;
         red_count = RED_COUNT_RST;
         timeout   = TIMEOUT_RST;
      endfunction

      function int maps_in_use();
         return (map_count > MAP_N) ? MAP_N : int'(map_count);
      endfunction

      function int reduces_in_use();
         return (red_count > RED_N) ? RED_N : int'(red_count);
      endfunction

      function bit all_done(bit red_side, int n);
         int i;
         for (i = 0; i < n; i++) begin
            if ((red_side ? red_state[i] : map_state[i]) != ST_DONE)
               return 1'b0;
         end
         return 1'b1;
      endfunction

      // tasks not yet completed within the given in-use counts
      function int open_tasks(int nm, int nr);
         int i;
         int n;
         n = 0;
         for (i = 0; i < nm; i++)
            if (map_state[i] != ST_DONE) n++;
         for (i = 0; i < nr; i++)
            if (red_state[i] != ST_DONE) n++;
         return n;
      endfunction

      // first idle or timed-out entry; marks it in progress
      function int claim_slot(bit red_side, int n, logic [WORKER_W-1:0] worker,
                              output logic again);
         int i;
         logic [1:0] st;
         logic [NOW_W-1:0] age;
         again = 1'b0;
         for (i = 0; i < n; i++) begin
            st  = red_side ? red_state[i] : map_state[i];
            age = seconds - (red_side ? red_stamp[i] : map_stamp[i]);
            if (st == ST_IDLE || (st == ST_BUSY && age > NOW_W'(timeout))) begin
               again = (st == ST_BUSY);
               if (red_side) begin
                  red_state[i] = ST_BUSY;
                  red_stamp[i] = seconds;
                  red_owner[i] = worker;
               end else begin
                  map_state[i] = ST_BUSY;
                  map_stamp[i] = seconds;
                  map_owner[i] = worker;
               end
               return i;
            end
         end
         return -1;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DAT_W-1:0] data);
         case (index)
            REG_MAP_COUNT: begin
               map_count = data[MCOUNT_W-1:0];
            end
            REG_RED_COUNT: begin
               red_count = data[RCOUNT_W-1:0];
            end
            REG_TIMEOUT: begin
               timeout = data[TIMEOUT_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // true when this done report would close the last open task
      function bit completes_job(logic [FUNC_W-1:0] func, logic [KIND_W-1:0] kind,
                                 logic [TASK_W-1:0] slot);
         int nm;
         int nr;
         nm = maps_in_use();
         nr = reduces_in_use();
         if (finished || func != FN_DONE)
            return 1'b0;
         if ((kind == KIND_MAP && slot < nm && map_state[slot] == ST_BUSY) ||
             (kind == KIND_REDUCE && slot < nr && red_state[slot] == ST_BUSY))
            return open_tasks(nm, nr) == 1;
         return 1'b0;
      endfunction

      // random in-progress task of one kind, or -1
      function int busy_task(logic [KIND_W-1:0] kind);
         int hits[$];
         int i;
         int n;
         n = (kind == KIND_MAP) ? maps_in_use() : reduces_in_use();
         for (i = 0; i < n; i++)
            if (((kind == KIND_MAP) ? map_state[i] : red_state[i]) == ST_BUSY)
               hits.insert(hits.size(), i);
         if (hits.size() == 0)
            return -1;
         return hits[$urandom_range(0, hits.size() - 1)];
      endfunction

      function void note_request(logic [FUNC_W-1:0] func, logic [KIND_W-1:0] kind,
                                 logic [TASK_W-1:0] slot, logic [WORKER_W-1:0] worker);
         answer_type ans;
         int nm;
         int nr;
         int pick;
         logic again;
         nm = maps_in_use();
         nr = reduces_in_use();
         if (func == FN_TICK) begin
            seconds = seconds + 1;
            ticks++;
            return;
         end
         if (func == FN_UNUSED) begin
            ignored++;
            return;
         end
         // apply the done report, then look for completion
         if (!finished) begin
            if (func == FN_DONE) begin
               if (kind == KIND_MAP && slot < nm && map_state[slot] == ST_BUSY)
                  map_state[slot] = ST_DONE;
               else if (kind == KIND_REDUCE && slot < nr && red_state[slot] == ST_BUSY)
                  red_state[slot] = ST_DONE;
            end
            if (all_done(1'b0, nm) && all_done(1'b1, nr))
               finished = 1'b1;
         end
         ans.reply    = RPLY_WAIT;
         ans.index    = '0;
         ans.reissued = 1'b0;
         // maps first, reduces only once every map is complete
         if (finished) begin
            ans.reply = RPLY_ALLDONE;
         end else begin
            pick = claim_slot(1'b0, nm, worker, again);
            if (pick >= 0) begin
               ans.reply    = RPLY_MAP;
               ans.index    = TASK_W'(pick);
               ans.reissued = again;
            end else if (all_done(1'b0, nm)) begin
               pick = claim_slot(1'b1, nr, worker, again);
               if (pick >= 0) begin
                  ans.reply    = RPLY_REDUCE;
                  ans.index    = TASK_W'(pick);
                  ans.reissued = again;
               end
            end
         end
         answers_due.insert(answers_due.size(), ans);
      endfunction

      function void check_response(logic [REPLY_W-1:0] reply, logic [TASK_W-1:0] index,
                                   logic reissued);
         answer_type due;
         if (answers_due.size() == 0) begin
            $error("unexpected response: reply %0d task_index %0d reissued %0d",
                   reply, index, reissued);
            errors++;
            return;
         end
         due = answers_due.pop_front();
         if (reply !== due.reply) begin
            $error("reply: expected %0d, actual %0d", due.reply, reply);
            errors++;
         end
         if (index !== due.index) begin
            $error("task_index: expected %0d, actual %0d", due.index, index);
            errors++;
         end
         if (reissued !== due.reissued) begin
            $error("reissued: expected %0d, actual %0d", due.reissued, reissued);
            errors++;
         end
         tally[int'(due.reply)]++;
         if (due.reissued)
            reissues++;
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [FUNC_W-1:0]     req_func;
   logic [KIND_W-1:0]     req_done_kind;
   logic [TASK_W-1:0]     req_done_task;
   logic [WORKER_W-1:0]   req_worker_id;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [REPLY_W-1:0]    rsp_reply;
   logic [TASK_W-1:0]     rsp_task_index;
   logic                  rsp_reissued;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DAT_W-1:0]  csr_wdata;

   dispatcher_shadow board;
   bit quiet        = 1'b0;
   bit closing      = 1'b0;
   bit hold_request = 1'b0;
   int sent         = 0;
   int phases       = 0;

   two_phase_task_dispatcher DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_done_kind  (req_done_kind),
      .req_done_task  (req_done_task),
      .req_worker_id  (req_worker_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reply      (rsp_reply),
      .rsp_task_index (rsp_task_index),
      .rsp_reissued   (rsp_reissued),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // clock
   always #6 clock = ~clock;

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_reply, rsp_task_index, rsp_reissued);
   end

   // response side: random stall bursts and one long hold-off
   initial begin
      int span;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_request = 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < 7) begin
            span = $urandom_range(1, 18);
            rsp_stall <= 1'b1;
            repeat (span) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // overall run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("Regression FAIL");
      $finish;
   end

   // offer one request and wait for it to be taken
   task automatic issue(input logic [FUNC_W-1:0] func, input logic [KIND_W-1:0] kind,
                        input logic [TASK_W-1:0] slot, input logic [WORKER_W-1:0] worker);
      int gap;
      logic [KIND_W-1:0] sent_kind;
      sent_kind = kind;
      // keep the job open until the closing part
      if (!closing && board.completes_job(func, kind, slot))
         sent_kind = KIND_OTHER;
      // random sender gap
      if (!quiet && $urandom_range(0, 99) < 9) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_func      <= func;
      req_done_kind <= sent_kind;
      req_done_task <= slot;
      req_worker_id <= worker;
      do @(posedge clock); while (req_stall);
      board.note_request(func, sent_kind, slot, worker);
      if (func != FN_UNUSED)
         sent++;
   endtask

   // stop offering, wait for every answer, then let in-flight ticks finish
   task automatic settle();
      int waited;
      @(negedge clock);
      req_valid <= 1'b0;
      waited = 0;
      while (board.answers_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.set_register(index, data);
   endtask

   // per-phase register setting, never one that closes the job early
   task automatic configure(input int p);
      int mc;
      int rc;
      int tmo;
      logic [CSR_DAT_W-1:0] word;
      case (p % 6)
         0: begin
            mc = MAP_N; rc = RED_N; tmo = 65535;
         end
         1: begin
            mc = 63; rc = 31; tmo = 0;
         end
         2: begin
            mc = $urandom_range(1, 8); rc = $urandom_range(0, 4); tmo = $urandom_range(1, 6);
         end
         3: begin
            mc = 0; rc = $urandom_range(1, RED_N); tmo = 2;
         end
         4: begin
            mc = $urandom_range(1, MAP_N); rc = $urandom_range(0, RED_N);
            tmo = $urandom_range(0, 65535);
         end
         default: begin
            mc = 1; rc = 0; tmo = $urandom_range(1, 4);
         end
      endcase
      if (board.open_tasks((mc > MAP_N) ? MAP_N : mc, (rc > RED_N) ? RED_N : rc) == 0) begin
         mc = MAP_N;
         rc = RED_N;
      end
      write_register(REG_TIMEOUT, CSR_DAT_W'(tmo));
      word = CSR_DAT_W'($urandom);
      word[MCOUNT_W-1:0] = MCOUNT_W'(mc);
      write_register(REG_MAP_COUNT, word);
      word = CSR_DAT_W'($urandom);
      word[RCOUNT_W-1:0] = RCOUNT_W'(rc);
      write_register(REG_RED_COUNT, word);
      if (p % 6 == 1)
         write_register(REG_SPARE, CSR_DAT_W'($urandom));
   endtask

   // one random item, mostly requests, done reports for live tasks and ticks
   task automatic random_item();
      int r;
      int pick;
      logic [KIND_W-1:0] kind;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         issue(FN_REQUEST, KIND_W'($urandom), TASK_W'($urandom), WORKER_W'($urandom));
      end else if (r < 55) begin
         kind = $urandom_range(0, 1) ? KIND_REDUCE : KIND_MAP;
         pick = board.busy_task(kind);
         if (pick >= 0)
            issue(FN_DONE, kind, TASK_W'(pick), WORKER_W'($urandom));
         else
            issue(FN_DONE, KIND_MAP, TASK_W'($urandom), WORKER_W'($urandom));
      end else if (r < 70) begin
         issue(FN_DONE, KIND_W'($urandom), TASK_W'($urandom), WORKER_W'($urandom));
      end else if (r < 95) begin
         issue(FN_TICK, KIND_W'($urandom), TASK_W'($urandom), WORKER_W'($urandom));
      end else begin
         issue(FN_UNUSED, KIND_W'($urandom), TASK_W'($urandom), WORKER_W'($urandom));
      end
   endtask

   // main sequence
   initial begin
      int count;
      int guard;
      int pick;
      logic [KIND_W-1:0] kind;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = FN_REQUEST;
      req_done_kind = KIND_MAP;
      req_done_task = '0;
      req_worker_id = '0;
      csr_wr_en     = 1'b0;
      csr_index     = REG_MAP_COUNT;
      csr_wdata     = '0;
      board = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: default registers, one map and two reduces
      issue(FN_TICK, KIND_SPARE, 5'd31, 8'hFF);
      issue(FN_UNUSED, KIND_SPARE, 5'd31, 8'hFF);
      issue(FN_REQUEST, KIND_MAP, 5'd0, 8'h00);
      issue(FN_REQUEST, KIND_MAP, 5'd0, 8'hFF);
      // done reports that change nothing but still get an answer
      issue(FN_DONE, KIND_MAP, 5'd31, 8'h5A);
      issue(FN_DONE, KIND_REDUCE, 5'd0, 8'hA5);
      issue(FN_DONE, KIND_OTHER, 5'd0, 8'h01);
      issue(FN_DONE, KIND_SPARE, 5'd0, 8'h80);
      // last map completes, reduces open up
      issue(FN_DONE, KIND_MAP, 5'd0, 8'h7F);
      issue(FN_REQUEST, KIND_MAP, 5'd0, 8'h3C);
      issue(FN_REQUEST, KIND_MAP, 5'd0, 8'hC3);
      issue(FN_DONE, KIND_MAP, 5'd0, 8'h11);
      // zero timeout: any elapsed second allows reassignment
      settle();
      write_register(REG_TIMEOUT, '0);
      issue(FN_TICK, KIND_MAP, 5'd0, 8'h00);
      issue(FN_REQUEST, KIND_MAP, 5'd0, 8'h22);
      issue(FN_DONE, KIND_REDUCE, 5'd0, 8'h33);
      // no map tasks at all
      settle();
      write_register(REG_MAP_COUNT, '0);
      write_register(REG_RED_COUNT, CSR_DAT_W'(4));
      issue(FN_REQUEST, KIND_MAP, 5'd0, 8'h44);
      issue(FN_REQUEST, KIND_MAP, 5'd0, 8'h55);

      // random phases, each with its own register setting
      while (sent < RANDOM_ITEMS) begin
         settle();
         configure(phases);
         quiet = (phases % 4 == 3);
         if (phases == 2)
            hold_request = 1'b1;
         count = $urandom_range(60, 140);
         repeat (count) random_item();
         phases++;
      end

      // closing: no idling, drive the job to completion
      settle();
      quiet   = 1'b1;
      closing = 1'b1;
      guard   = 0;
      while (!board.finished && guard < 2000) begin
         kind = board.all_done(1'b0, board.maps_in_use()) ? KIND_REDUCE : KIND_MAP;
         pick = board.busy_task(kind);
         if (pick >= 0 && $urandom_range(0, 1))
            issue(FN_DONE, kind, TASK_W'(pick), WORKER_W'($urandom));
         else
            issue(FN_REQUEST, KIND_W'($urandom), TASK_W'($urandom), WORKER_W'($urandom));
         guard++;
      end
      // finished job keeps answering all done, ticks still counted
      repeat (16) random_item();
      settle();

      if (board.answers_due.size() != 0) begin
         $error("%0d answers still outstanding at end of run", board.answers_due.size());
         board.errors++;
      end
      $display("%0d answers over %0d register settings: %0d map, %0d reduce, %0d wait, %0d done",
               board.tally[0] + board.tally[1] + board.tally[2] + board.tally[3], phases + 3,
               board.tally[int'(RPLY_MAP)], board.tally[int'(RPLY_REDUCE)],
               board.tally[int'(RPLY_WAIT)], board.tally[int'(RPLY_ALLDONE)]);
      $display("%0d timed-out tasks handed out again, %0d ticks, %0d unused codes dropped",
               board.reissues, board.ticks, board.ignored);
      if (board.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
